@@ hdl/cartridge_bank_switch_mapper_macros.svh @@
// Assertion macros for the cartridge bank switch mapper.
// Used by cartridge_bank_switch_mapper.sv; expects clk and arst_n in scope.
`ifndef CARTRIDGE_BANK_SWITCH_MAPPER_MACROS_SVH
`define CARTRIDGE_BANK_SWITCH_MAPPER_MACROS_SVH
`ifndef SYNTH
// checked only outside reset
`define CBSM_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("cbsm assertion failed");
// checked at every edge, reset included
`define CBSM_ASSERT_ALWAYS(label, prop) \
	label: assert property (@(posedge clk) prop) \
	else $error("cbsm assertion failed");
`else
`define CBSM_ASSERT(label, prop)
`define CBSM_ASSERT_ALWAYS(label, prop)
`endif
`endif

@@ hdl/cbsm_pkg.sv @@
// Shared types, constants and helpers for the cartridge bank switch mapper.
// No dependencies.
package cbsm_pkg;

	localparam int PRG_RAM_BYTES = 2048;
	localparam int PRG_RAM_AW    = $clog2(PRG_RAM_BYTES);

	typedef enum logic [1:0] {
		CMD_CPU_READ  = 2'd0,
		CMD_CPU_WRITE = 2'd1,
		CMD_PPU_READ  = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		TGT_NONE    = 2'd0,
		TGT_PRG_ROM = 2'd1,
		TGT_PRG_RAM = 2'd2,
		TGT_CHR     = 2'd3
	} target_t;

	localparam logic [1:0] MIR_VERTICAL   = 2'd0;
	localparam logic [1:0] MIR_HORIZONTAL = 2'd1;
	localparam logic [1:0] MIR_FOUR       = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_PRG_LOG2   = 2'd0;
	localparam logic [1:0] CFG_ALT_LAYOUT = 2'd1;
	localparam logic [1:0] CFG_HORIZ      = 2'd2;

	localparam logic [2:0] PRG_LOG2_MAX = 3'd6;

	localparam logic [15:0] ADDR_RAM_BASE   = 16'h6000;
	localparam logic [15:0] ADDR_ROM_BASE   = 16'h8000;
	localparam logic [15:0] ADDR_MIRROR_REG = 16'hA000;
	localparam logic [15:0] ADDR_IRQ_REG    = 16'hC000;
	localparam logic [15:0] ADDR_CHR_LIMIT  = 16'h2000;

	function automatic logic [1:0] mirror_reload(input logic alt, input logic horiz);
		if (alt)
			return MIR_FOUR;
		return horiz ? MIR_VERTICAL : MIR_HORIZONTAL;
	endfunction

endpackage

@@ hdl/cartridge_bank_switch_mapper.sv @@
// Bank switch mapper: one word per cycle unless rsp_stall holds the result register.
// An accepted word goes to the input register, then to the result register, where it is
// shown with result valid. A bank register write is seen by the very next word, since
// state updates as a word leaves the input register. Configuration is always
// ready and reloads mirroring on a layout or horizontal-arrangement write.
// Depends on cbsm_pkg and cartridge_bank_switch_mapper_macros.svh.
`include "cartridge_bank_switch_mapper_macros.svh"

module cartridge_bank_switch_mapper
	import cbsm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  command,
	input  logic [15:0] address,
	input  logic [7:0]  data,

	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [1:0]  target,
	output logic [18:0] mapped_address,
	output logic [1:0]  mirroring,

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [2:0]  cfg_data
);

	// configuration and mapper state
	logic [2:0] cfg_log2_q;
	logic       cfg_alt_q;
	logic       cfg_horiz_q;
	logic [2:0] bank_index_q;
	logic       prg_swap_q;
	logic       chr_inv_q;
	logic [6:0] bank_regs_q [8];
	logic [1:0] mirror_q;

	// input stage
	logic        valid_s1;
	cmd_t        command_s1;
	logic [15:0] address_s1;
	logic [7:0]  data_s1;

	// result register
	logic        rsp_valid_q;
	target_t     target_q;
	logic [18:0] mapped_q;
	logic [1:0]  mirror_out_q;

	logic s1_adv;

	// combinational results
	target_t     target_c;
	logic [18:0] mapped_c;
	logic [1:0]  mirror_nxt;
	logic        sel_wr;
	logic        reg_wr;

	logic [2:0]  prg_lg;
	logic [6:0]  prg_count;
	logic [5:0]  prg_mask;
	logic [5:0]  prg_second;
	logic [5:0]  prg_bank;
	logic [18:0] prg_addr;
	logic [2:0]  chr_slot;
	logic [2:0]  chr_idx;
	logic [6:0]  chr_reg;
	logic [6:0]  chr_bank;
	logic [18:0] chr_addr;
	logic [18:0] ram_addr;

	assign s1_adv    = !rsp_valid_q || !rsp_stall;
	assign req_stall = valid_s1 && !s1_adv;
	assign cfg_ready = 1'b1;

	assign rsp_valid      = rsp_valid_q;
	assign target         = target_q;
	assign mapped_address = mapped_q;
	assign mirroring      = mirror_out_q;

	// PRG ROM slot mapping; bank count is a power of two, so mask the bank
	always_comb begin
		prg_lg     = (cfg_log2_q > PRG_LOG2_MAX) ? PRG_LOG2_MAX : cfg_log2_q;
		prg_count  = 7'd1 << prg_lg;
		prg_mask   = 6'(prg_count - 7'd1);
		prg_second = 6'(prg_count - 7'd2);
		case (address_s1[14:13])
			2'd1:    prg_bank = bank_regs_q[7][5:0];
			2'd3:    prg_bank = prg_mask;
			default: prg_bank = ((address_s1[14:13] == 2'd0) == !prg_swap_q) ?
				bank_regs_q[6][5:0] : prg_second;
		endcase
		prg_bank = prg_bank & prg_mask;
		prg_addr = {prg_bank, address_s1[12:0]};
	end

	// CHR: slots 0-3 pair up on R0/R1, slots 4-7 use R2-R5
	always_comb begin
		chr_slot = address_s1[12:10] ^ {chr_inv_q, 2'b00};
		chr_idx  = chr_slot[2] ? (chr_slot - 3'd2) : {2'b00, chr_slot[1]};
		chr_reg  = bank_regs_q[chr_idx];
		chr_bank = chr_slot[2] ? chr_reg : {chr_reg[6:1], chr_slot[0]};
		chr_addr = {2'b00, chr_bank, address_s1[9:0]};
	end

	assign ram_addr = 19'(address_s1[PRG_RAM_AW-1:0]);

	always_comb begin
		target_c   = TGT_NONE;
		mapped_c   = '0;
		mirror_nxt = mirror_q;
		sel_wr     = 1'b0;
		reg_wr     = 1'b0;
		unique case (command_s1)
			CMD_CPU_READ: begin
				if (address_s1 >= ADDR_ROM_BASE) begin
					target_c = TGT_PRG_ROM;
					mapped_c = prg_addr;
				end else if (address_s1 >= ADDR_RAM_BASE) begin
					target_c = TGT_PRG_RAM;
					mapped_c = ram_addr;
				end
			end
			CMD_CPU_WRITE: begin
				if (address_s1 >= ADDR_RAM_BASE && address_s1 < ADDR_ROM_BASE) begin
					target_c = TGT_PRG_RAM;
					mapped_c = ram_addr;
				end else if (address_s1 >= ADDR_ROM_BASE &&
					address_s1 < ADDR_MIRROR_REG) begin
					sel_wr = !address_s1[0];
					reg_wr = address_s1[0];
				end else if (address_s1 >= ADDR_MIRROR_REG &&
					address_s1 < ADDR_IRQ_REG) begin
					if (!address_s1[0] && !cfg_alt_q)
						mirror_nxt = {1'b0, data_s1[0]};
				end
			end
			CMD_PPU_READ: begin
				if (address_s1 < ADDR_CHR_LIMIT) begin
					target_c = TGT_CHR;
					mapped_c = chr_addr;
				end
			end
			default: ;
		endcase
	end

	// pipeline registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (!req_stall)
				valid_s1 <= req_valid;
			if (s1_adv)
				rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			command_s1 <= cmd_t'(command);
			address_s1 <= address;
			data_s1    <= data;
		end
		if (s1_adv && valid_s1) begin
			target_q     <= target_c;
			mapped_q     <= mapped_c;
			mirror_out_q <= mirror_nxt;
		end
	end

	// mapper and configuration state; mapper state updates as a word leaves the input stage, configuration on cfg_valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_log2_q   <= 3'd1;
			cfg_alt_q    <= 1'b0;
			cfg_horiz_q  <= 1'b0;
			bank_index_q <= '0;
			prg_swap_q   <= 1'b0;
			chr_inv_q    <= 1'b0;
			for (int i = 0; i < 8; i++)
				bank_regs_q[i] <= '0;
			mirror_q     <= mirror_reload(1'b0, 1'b0);
		end else begin
			if (s1_adv && valid_s1) begin
				if (sel_wr) begin
					bank_index_q <= data_s1[2:0];
					prg_swap_q   <= data_s1[6];
					chr_inv_q    <= data_s1[7];
				end
				if (reg_wr)
					bank_regs_q[bank_index_q] <= data_s1[6:0];
				mirror_q <= mirror_nxt;
			end
			if (cfg_valid) begin
				case (cfg_index)
					CFG_PRG_LOG2: cfg_log2_q <= cfg_data;
					CFG_ALT_LAYOUT: begin
						cfg_alt_q <= cfg_data[0];
						mirror_q  <= mirror_reload(cfg_data[0], cfg_horiz_q);
					end
					CFG_HORIZ: begin
						cfg_horiz_q <= cfg_data[0];
						mirror_q    <= mirror_reload(cfg_alt_q, cfg_data[0]);
					end
					default: ;
				endcase
			end
		end
	end

	`CBSM_ASSERT_ALWAYS(a_no_stall_when_empty, !valid_s1 |-> !req_stall)
	`CBSM_ASSERT(a_s1_reaches_output, (valid_s1 && s1_adv) |=> rsp_valid)
	`CBSM_ASSERT(a_unmapped_zero_addr, (rsp_valid && target == TGT_NONE) |-> mapped_address == '0)
	`CBSM_ASSERT(a_chr_addr_range, (rsp_valid && target == TGT_CHR) |-> mapped_address[18:17] == 2'b00)
	`CBSM_ASSERT(a_four_screen_held, cfg_alt_q |-> mirror_q == MIR_FOUR)

endmodule
